// ===== rtl/rtbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rtbe_pkg;

    localparam int BUDGET_W = 22;
    localparam int CODE_W   = 8;
    localparam int CFG_W    = 16;
    localparam int WORD_W   = 32;
    localparam int MP_W     = 26;
    localparam int PLL_W    = 31;
    localparam int RANGE_W  = 20;
    localparam int EXPO_W   = 5;

    localparam logic [BUDGET_W-1:0] RANGE_LIMIT_US = 22'd1100000;
    localparam logic [9:0]          PHASECAL_US    = 10'd1000;
    localparam logic [7:0]          PHASECAL_MAX   = 8'hFF;
    localparam logic [WORD_W-1:0]   PLL_NUMERATOR  = 32'h4000_0000;

    // Configuration register indexes.
    localparam logic REG_OSC_FREQ = 1'b0;
    localparam logic REG_GUARD    = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_GUARD = 2'd1;
    localparam logic [1:0] ST_BIG   = 2'd2;
    localparam logic [1:0] ST_OSC   = 2'd3;

    // Conversion jobs, in the order they run.
    localparam logic [2:0] JOB_PC_A  = 3'd0;
    localparam logic [2:0] JOB_MM_A  = 3'd1;
    localparam logic [2:0] JOB_RNG_A = 3'd2;
    localparam logic [2:0] JOB_MM_B  = 3'd3;
    localparam logic [2:0] JOB_RNG_B = 3'd4;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHK    = 7'b0000010,
        S_PLL    = 7'b0000100,
        S_MP     = 7'b0001000,
        S_DSTART = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_ENC    = 7'b1000000
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/rtbe_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtbe_div
    import rtbe_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic [WORD_W+1:0] diff;
    logic              ge;

    // One quotient bit per cycle. A zero divisor yields all ones.
    always_comb begin
        diff      = {1'b0, rem_reg, quo_reg[WORD_W-1]} - {2'b00, den_reg};
        ge        = ~diff[WORD_W+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next = ge ? diff[WORD_W-1:0] : {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
            quo_next = {quo_reg[WORD_W-2:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/rtbe_enc.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtbe_enc
    import rtbe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] clks,
    output logic                   done,
    output logic [15:0]            code
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] mant_reg, mant_next;
    logic [EXPO_W-1:0] expo_reg, expo_next;

    // The mantissa is shifted right one place per cycle until it fits a byte.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mant_next = mant_reg;
        expo_next = expo_reg;
        if (start) begin
            expo_next = '0;
            if (clks == '0) begin
                mant_next = '0;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                mant_next = clks - 32'd1;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (mant_reg[WORD_W-1:8] != '0) begin
                mant_next = {1'b0, mant_reg[WORD_W-1:1]};
                expo_next = expo_reg + 5'd1;
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mant_reg <= mant_next;
        expo_reg <= expo_next;
    end

    assign done = done_reg;
    assign code = {3'b000, expo_reg, mant_reg[7:0]};

endmodule
`default_nettype wire

// ===== rtl/ranging_timing_budget_encoder.sv =====
// Ranging timing budget encoder.
// Input channel s_*: a timing budget in microseconds and the two laser period
// codes, transferred on s_valid and s_ready. Result channel m_*: status, the
// phase calibration timeout and four encoded timeouts, transferred on m_valid
// and m_ready. Configuration is written through cfg_we, cfg_addr and
// cfg_wdata: index 0 is the oscillator frequency, index 1 the guard time.
// The user must write the configuration only while the block is idle; the
// block itself does not enforce this. One item is processed at a time. An
// item that fails the guard, range or oscillator check is rejected in S_CHK.
// A good one runs six 32-bit divisions on one shared restoring divider and a
// serial mantissa normalization for four of them. In both cases m_valid rises
// once the result is loaded into the output register.
// Results sit in an output register; a new item is taken while a result still
// waits, but the next result holds until the receiver takes the old one.
// Reset returns the sequencer to idle, drops m_valid, sets the oscillator
// frequency to 0 and the guard time to 4528 us.
`timescale 1ns / 1ps
`default_nettype none
module ranging_timing_budget_encoder
    import rtbe_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_addr,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [BUDGET_W-1:0] s_budget_us,
    input  wire logic [CODE_W-1:0]   s_vcsel_period_a,
    input  wire logic [CODE_W-1:0]   s_vcsel_period_b,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic [7:0]               m_phasecal_timeout,
    output logic [15:0]              m_mm_timeout_a,
    output logic [15:0]              m_range_timeout_a,
    output logic [15:0]              m_mm_timeout_b,
    output logic [15:0]              m_range_timeout_b
);

    state_t state_reg, state_next;
    logic [2:0]          job_reg, job_next;
    logic [CFG_W-1:0]    osc_reg, guard_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic [CODE_W-1:0]   code_a_reg, code_b_reg;
    logic [RANGE_W-1:0]  range_reg, range_next;
    logic [PLL_W-1:0]    pll_reg, pll_next;
    logic [MP_W-1:0]     mp_reg, mp_next;
    logic [1:0]          status_reg, status_next;
    logic [7:0]          pc_reg, pc_next;
    logic [15:0]         mma_reg, mma_next, rnga_reg, rnga_next;
    logic [15:0]         mmb_reg, mmb_next, rngb_reg, rngb_next;
    logic                pend_reg, pend_next;
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          o_status_reg;
    logic [7:0]          o_pc_reg;
    logic [15:0]         o_mma_reg, o_rnga_reg, o_mmb_reg, o_rngb_reg;
    logic                load_out;

    div_req_t            dreq;
    div_rsp_t            drsp;
    logic                enc_start, enc_done;
    logic [15:0]         enc_code;

    logic [BUDGET_W-1:0] diff;
    logic [CODE_W-1:0]   code_sel, pclks;
    logic [23:0]         pll9;
    logic [MP_W-1:0]     m1;
    logic [MP_W+CODE_W-1:0] prod;
    logic [RANGE_W-1:0]  us_sel;
    logic [WORD_W-1:0]   num_sel;
    logic [2:0]          job_inc;

    rtbe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    rtbe_enc u_enc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (enc_start),
        .clks    (drsp.quot),
        .done    (enc_done),
        .code    (enc_code)
    );

    assign s_ready = (state_reg == S_IDLE) && !pend_reg;

    // Datapath for the guard check and the macro period.
    always_comb begin
        diff     = budget_reg - {{(BUDGET_W-CFG_W){1'b0}}, guard_reg};
        code_sel = (job_reg < JOB_MM_B) ? code_a_reg : code_b_reg;
        pclks    = {code_sel[6:0] + 7'd1, 1'b0};
        // 2304 * pll wraps at 32 bits; after the shift by 6 only the low 24 bits
        // of 9 * pll survive.
        pll9     = pll_reg[23:0] + {pll_reg[20:0], 3'b000};
        m1       = {pll9, 2'b00};
        prod     = m1 * pclks;
        case (job_reg)
            JOB_PC_A:            us_sel = {{(RANGE_W-10){1'b0}}, PHASECAL_US};
            JOB_MM_A, JOB_MM_B:  us_sel = {{(RANGE_W-1){1'b0}}, 1'b1};
            default:             us_sel = range_reg;
        endcase
        num_sel  = {us_sel, 12'd0} + {7'd0, mp_reg[MP_W-1:1]};
        job_inc  = job_reg + 3'd1;
    end

    always_comb begin
        state_next  = state_reg;
        job_next    = job_reg;
        range_next  = range_reg;
        pll_next    = pll_reg;
        mp_next     = mp_reg;
        status_next = status_reg;
        pc_next     = pc_reg;
        mma_next    = mma_reg;
        rnga_next   = rnga_reg;
        mmb_next    = mmb_reg;
        rngb_next   = rngb_reg;
        pend_next   = pend_reg;
        dreq.start  = 1'b0;
        dreq.num    = PLL_NUMERATOR;
        dreq.den    = {{(WORD_W-CFG_W){1'b0}}, osc_reg};
        enc_start   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                pc_next   = '0;
                mma_next  = '0;
                rnga_next = '0;
                mmb_next  = '0;
                rngb_next = '0;
                if (budget_reg <= {{(BUDGET_W-CFG_W){1'b0}}, guard_reg}) begin
                    status_next = ST_GUARD;
                    pend_next   = 1'b1;
                    state_next  = S_IDLE;
                end else if (diff > RANGE_LIMIT_US) begin
                    status_next = ST_BIG;
                    pend_next   = 1'b1;
                    state_next  = S_IDLE;
                end else if (osc_reg == '0) begin
                    status_next = ST_OSC;
                    pend_next   = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    status_next = ST_OK;
                    range_next  = diff[RANGE_W:1];
                    dreq.start  = 1'b1;
                    state_next  = S_PLL;
                end
            end
            S_PLL: begin
                if (drsp.done) begin
                    pll_next   = drsp.quot[PLL_W-1:0];
                    job_next   = JOB_PC_A;
                    state_next = S_MP;
                end
            end
            S_MP: begin
                mp_next    = prod[WORD_W-1:6];
                state_next = S_DSTART;
            end
            S_DSTART: begin
                dreq.start = 1'b1;
                dreq.num   = num_sel;
                dreq.den   = {{(WORD_W-MP_W){1'b0}}, mp_reg};
                state_next = S_DIV;
            end
            S_DIV: begin
                if (drsp.done) begin
                    if (job_reg == JOB_PC_A) begin
                        pc_next    = (drsp.quot > {24'd0, PHASECAL_MAX}) ?
                                     PHASECAL_MAX : drsp.quot[7:0];
                        job_next   = job_inc;
                        state_next = S_DSTART;
                    end else begin
                        enc_start  = 1'b1;
                        state_next = S_ENC;
                    end
                end
            end
            S_ENC: begin
                if (enc_done) begin
                    case (job_reg)
                        JOB_MM_A:  mma_next  = enc_code;
                        JOB_RNG_A: rnga_next = enc_code;
                        JOB_MM_B:  mmb_next  = enc_code;
                        default:   rngb_next = enc_code;
                    endcase
                    job_next = job_inc;
                    if (job_reg == JOB_RNG_B) begin
                        pend_next  = 1'b1;
                        state_next = S_IDLE;
                    end else if (job_inc == JOB_MM_B) begin
                        state_next = S_MP;
                    end else begin
                        state_next = S_DSTART;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // A finished result moves to the output register once it is free.
        load_out     = pend_reg && (!m_valid_reg || m_ready);
        m_valid_next = m_valid_reg && !m_ready;
        if (load_out) begin
            pend_next    = 1'b0;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            job_reg     <= JOB_PC_A;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            osc_reg     <= '0;
            guard_reg   <= 16'd4528;
        end else begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_OSC_FREQ: osc_reg   <= cfg_wdata;
                    REG_GUARD:    guard_reg <= cfg_wdata;
                    default:      osc_reg   <= osc_reg;
                endcase
            end
        end
        if (s_valid && s_ready) begin
            budget_reg <= s_budget_us;
            code_a_reg <= s_vcsel_period_a;
            code_b_reg <= s_vcsel_period_b;
        end
        range_reg  <= range_next;
        pll_reg    <= pll_next;
        mp_reg     <= mp_next;
        status_reg <= status_next;
        pc_reg     <= pc_next;
        mma_reg    <= mma_next;
        rnga_reg   <= rnga_next;
        mmb_reg    <= mmb_next;
        rngb_reg   <= rngb_next;
        if (load_out) begin
            o_status_reg <= status_reg;
            o_pc_reg     <= pc_reg;
            o_mma_reg    <= mma_reg;
            o_rnga_reg   <= rnga_reg;
            o_mmb_reg    <= mmb_reg;
            o_rngb_reg   <= rngb_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = o_status_reg;
    assign m_phasecal_timeout = o_pc_reg;
    assign m_mm_timeout_a     = o_mma_reg;
    assign m_range_timeout_a  = o_rnga_reg;
    assign m_mm_timeout_b     = o_mmb_reg;
    assign m_range_timeout_b  = o_rngb_reg;

endmodule
`default_nettype wire
